FILE: rtl/core/lcdt_pkg.sv
// Package for the LCD line timing and STAT interrupt block.
// Holds timing constants, mode codes, register indexes, shared structs
// and the STAT condition function. No dependencies.
`default_nettype none

package lcdt_pkg;

	// Line and frame timing
	localparam int unsigned DOT_W  = 9;
	localparam int unsigned LINE_W = 8;

	localparam logic [DOT_W-1:0]  DOTS_PER_LINE = 9'd456;
	localparam logic [DOT_W-1:0]  SEARCH_END    = 9'd80;
	localparam logic [DOT_W-1:0]  TRANSFER_END  = 9'd252;
	localparam logic [LINE_W-1:0] LAST_LINE     = 8'd153;
	localparam logic [LINE_W-1:0] FIRST_VBLANK  = 8'd144;

	// Configuration port
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_LCD_ENABLE      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STAT_IRQ_ENABLE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_COMPARE    = 2'd2;

	// STAT interrupt enable bit positions
	localparam int unsigned STAT_EN_MODE0 = 0;
	localparam int unsigned STAT_EN_MODE1 = 1;
	localparam int unsigned STAT_EN_MODE2 = 2;
	localparam int unsigned STAT_EN_MATCH = 3;

	typedef enum logic [1:0] {
		MODE_HBLANK   = 2'd0,
		MODE_VBLANK   = 2'd1,
		MODE_SEARCH   = 2'd2,
		MODE_TRANSFER = 2'd3
	} mode_t;

	typedef struct packed {
		logic              lcd_enable;
		logic [3:0]        stat_irq_enable;
		logic [LINE_W-1:0] line_compare;
	} cfg_t;

	typedef struct packed {
		logic [LINE_W-1:0] line_number;
		logic [1:0]        lcd_mode;
		logic              line_match;
		logic              stat_irq;
		logic              vblank_irq;
		logic              hblank_start;
	} result_t;

	// Combined STAT condition for a given line and mode
	function automatic logic stat_cond(input logic [3:0] en, input logic [LINE_W-1:0] line,
			input logic [LINE_W-1:0] cmp, input mode_t mode);
		logic c;
		c = (en[STAT_EN_MATCH] && (line == cmp))
			|| (en[STAT_EN_MODE2] && (mode == MODE_SEARCH))
			|| (en[STAT_EN_MODE1] && (mode == MODE_VBLANK))
			|| (en[STAT_EN_MODE0] && (mode == MODE_HBLANK));
		return c;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/lcdt_in_if.sv
// Input channel of the LCD timing block: one dot tick per transaction.
// Stand-alone interface, no dependencies.
`default_nettype none

interface lcdt_in_if;
	logic valid;
	logic ready;
	logic dot_tick;

	modport source (output valid, output dot_tick, input ready);
	modport sink (input valid, input dot_tick, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/lcdt_out_if.sv
// Result channel of the LCD timing block: line, mode, flag and pulses.
// Widths follow lcdt_pkg.
`default_nettype none

interface lcdt_out_if;
	logic                              valid;
	logic                              ready;
	logic [lcdt_pkg::LINE_W-1:0]       line_number;
	logic [1:0]                        lcd_mode;
	logic                              line_match;
	logic                              stat_irq;
	logic                              vblank_irq;
	logic                              hblank_start;

	modport source (output valid, output line_number, output lcd_mode, output line_match,
		output stat_irq, output vblank_irq, output hblank_start, input ready);
	modport sink (input valid, input line_number, input lcd_mode, input line_match,
		input stat_irq, input vblank_irq, input hblank_start, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/lcdt_cfg.sv
// Configuration registers of the LCD timing block.
// Uses cfg_t and register indexes from lcdt_pkg.
`default_nettype none

module lcdt_cfg (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_wr_en,
	input  wire logic [lcdt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [lcdt_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	output lcdt_pkg::cfg_t                           cfg
);

	lcdt_pkg::cfg_t cfg_q;

	// Register writes; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lcd_enable      <= 1'b1;
			cfg_q.stat_irq_enable <= 4'd0;
			cfg_q.line_compare    <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				lcdt_pkg::CFG_LCD_ENABLE:      cfg_q.lcd_enable      <= cfg_wdata[0];
				lcdt_pkg::CFG_STAT_IRQ_ENABLE: cfg_q.stat_irq_enable <= cfg_wdata[3:0];
				lcdt_pkg::CFG_LINE_COMPARE:    cfg_q.line_compare    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/core/lcdt_seq.sv
// Dot/line counters, mode sequencing and STAT edge detector.
// Computes one step's result and updates state on step. Uses lcdt_pkg.
`default_nettype none

module lcdt_seq (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire logic             tick,
	input  wire lcdt_pkg::cfg_t   cfg,
	output lcdt_pkg::result_t     res
);

	logic [lcdt_pkg::DOT_W-1:0]  dot_q, dot_inc, dot_d;
	logic [lcdt_pkg::LINE_W-1:0] line_q, line_inc, line_d;
	lcdt_pkg::mode_t             mode_q, mode_calc, mode_d;
	logic                        match_q, match_d;
	logic                        lvl_q, lvl_d;
	logic                        mode_chg, line_end;
	logic                        cond1, cond2, lvl1, rise1, rise2;

	// Next dot, mode of that dot and next line
	always_comb begin
		dot_inc = dot_q + 9'd1;
		if (line_q >= lcdt_pkg::FIRST_VBLANK)
			mode_calc = lcdt_pkg::MODE_VBLANK;
		else if (dot_inc <= lcdt_pkg::SEARCH_END)
			mode_calc = lcdt_pkg::MODE_SEARCH;
		else if (dot_inc <= lcdt_pkg::TRANSFER_END)
			mode_calc = lcdt_pkg::MODE_TRANSFER;
		else
			mode_calc = lcdt_pkg::MODE_HBLANK;
		line_inc = (line_q >= lcdt_pkg::LAST_LINE) ? '0 : line_q + 8'd1;
		mode_chg = (mode_calc != mode_q);
		line_end = (dot_inc >= lcdt_pkg::DOTS_PER_LINE);
	end

	// STAT edge detection: on mode change (old line), then on line end (new line)
	always_comb begin
		cond1 = lcdt_pkg::stat_cond(cfg.stat_irq_enable, line_q, cfg.line_compare, mode_calc);
		rise1 = mode_chg && cond1 && !lvl_q;
		lvl1  = mode_chg ? cond1 : lvl_q;
		cond2 = lcdt_pkg::stat_cond(cfg.stat_irq_enable, line_inc, cfg.line_compare,
			mode_calc);
		rise2 = line_end && cond2 && !lvl1;
	end

	// Next state and result of this step
	always_comb begin
		dot_d   = dot_q;
		line_d  = line_q;
		mode_d  = mode_q;
		match_d = match_q;
		lvl_d   = lvl_q;
		res.stat_irq     = 1'b0;
		res.vblank_irq   = 1'b0;
		res.hblank_start = 1'b0;
		if (!cfg.lcd_enable) begin
			dot_d  = '0;
			line_d = '0;
			mode_d = lcdt_pkg::MODE_HBLANK;
		end else if (tick) begin
			mode_d = mode_calc;
			res.hblank_start = mode_chg && (mode_calc == lcdt_pkg::MODE_HBLANK);
			res.vblank_irq   = mode_chg && (mode_calc == lcdt_pkg::MODE_VBLANK);
			res.stat_irq     = rise1 || rise2;
			if (line_end) begin
				dot_d   = '0;
				line_d  = line_inc;
				match_d = (line_inc == cfg.line_compare);
				lvl_d   = cond2;
			end else begin
				dot_d = dot_inc;
				lvl_d = lvl1;
			end
		end
		res.line_number = line_d;
		res.lcd_mode    = mode_d;
		res.line_match  = match_d;
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q   <= '0;
			line_q  <= '0;
			mode_q  <= lcdt_pkg::MODE_VBLANK;
			match_q <= 1'b1;
			lvl_q   <= 1'b0;
		end else if (step) begin
			dot_q   <= dot_d;
			line_q  <= line_d;
			mode_q  <= mode_d;
			match_q <= match_d;
			lvl_q   <= lvl_d;
		end
	end

	// Checks
	a_line_range: assert property (@(posedge clk) disable iff (!arst_n)
		line_q <= lcdt_pkg::LAST_LINE) else $error("line counter out of range");
	a_dot_range: assert property (@(posedge clk) disable iff (!arst_n)
		dot_q < lcdt_pkg::DOTS_PER_LINE) else $error("dot counter out of range");
	a_vblank_mode: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.vblank_irq |=> mode_q == lcdt_pkg::MODE_VBLANK)
		else $error("vblank pulse without vblank mode");
	a_off_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg.lcd_enable |-> !res.stat_irq && !res.vblank_irq && !res.hblank_start)
		else $error("pulse while LCD is off");

endmodule

`default_nettype wire

FILE: rtl/core/lcd_line_timing_stat_irq.sv
// LCD line timing with STAT interrupt edge detection, top level.
// Registered path from input transaction to result: input register, then result register.
// Throughput: one dot per cycle while the result side takes results; the counters and edge detector update together.
// Reset (arst_n, asynchronous): line 0, dot 0, mode vblank, match flag set, LCD enabled.
// Depends on lcdt_pkg, lcdt_in_if, lcdt_out_if, lcdt_cfg and lcdt_seq.
`default_nettype none

module lcd_line_timing_stat_irq (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wr_en,
	input  wire logic [lcdt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [lcdt_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	lcdt_in_if.sink                                req,
	lcdt_out_if.source                             rsp
);

	lcdt_pkg::cfg_t    cfg;
	lcdt_pkg::result_t res, res_q;
	logic              valid_s1, tick_s1;
	logic              out_valid_q;
	logic              advance, step;

	lcdt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Pipeline moves whenever the result register is free or being drained
	assign advance   = !out_valid_q || rsp.ready;
	assign step      = valid_s1 && advance;
	assign req.ready = !valid_s1 || advance;

	lcdt_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.tick   (tick_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (req.ready)
			valid_s1 <= req.valid;
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready)
			tick_s1 <= req.dot_tick;
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (step)
			res_q <= res;
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.line_number  = res_q.line_number;
	assign rsp.lcd_mode     = res_q.lcd_mode;
	assign rsp.line_match   = res_q.line_match;
	assign rsp.stat_irq     = res_q.stat_irq;
	assign rsp.vblank_irq   = res_q.vblank_irq;
	assign rsp.hblank_start = res_q.hblank_start;

endmodule

`default_nettype wire

FILE: tb/tb_lcd_line_timing_stat_irq.sv
// Self-checking testbench for lcd_line_timing_stat_irq: predicts line, mode,
// coincidence flag and interrupt pulses per dot and checks every status transaction.
// Depends on lcdt_pkg, lcdt_in_if, lcdt_out_if and the RTL of the block.
`timescale 1ns / 100ps

module tb_lcd_line_timing_stat_irq;
	import lcdt_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 100_000;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned DRAIN_CYCLES = 6;

	// STAT enable masks
	localparam logic [3:0] EN_MODE0 = 4'(1 << STAT_EN_MODE0);
	localparam logic [3:0] EN_MODE1 = 4'(1 << STAT_EN_MODE1);
	localparam logic [3:0] EN_MODE2 = 4'(1 << STAT_EN_MODE2);
	localparam logic [3:0] EN_MATCH = 4'(1 << STAT_EN_MATCH);

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	lcdt_in_if req_if ();
	lcdt_out_if rsp_if ();

	lcd_line_timing_stat_irq dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req_if),
		.rsp       (rsp_if)
	);

	always #6 clk = ~clk;

	// Timing model: register copies and state, as after reset
	logic             lcd_on   = 1'b1;
	logic [3:0]       irq_en   = 4'd0;
	logic [LINE_W-1:0] lyc     = 8'd0;
	logic [DOT_W-1:0] dot_cnt  = '0;
	logic [LINE_W-1:0] line_cnt = '0;
	mode_t            cur_mode = MODE_VBLANK;
	logic             match_q  = 1'b1;
	logic             stat_q   = 1'b0;

	result_t status_due[$];
	int unsigned fails = 0;
	int unsigned cycle_count = 0;
	int unsigned src_idle_pct = 0;
	int unsigned snk_stall_pct = 0;
	int unsigned stall_hold = 0;

	// STAT line re-evaluation, returns the rising edge
	function automatic logic stat_rise();
		logic lvl;
		logic rise;
		lvl = (irq_en[STAT_EN_MATCH] && line_cnt == lyc)
			|| (irq_en[STAT_EN_MODE2] && cur_mode == MODE_SEARCH)
			|| (irq_en[STAT_EN_MODE1] && cur_mode == MODE_VBLANK)
			|| (irq_en[STAT_EN_MODE0] && cur_mode == MODE_HBLANK);
		rise = lvl && !stat_q;
		stat_q = lvl;
		return rise;
	endfunction

	// Advance the timing by one input transaction and return the expected status
	function automatic result_t advance_dot(input logic tick);
		result_t r;
		mode_t m;
		r = '0;
		if (!lcd_on) begin
			line_cnt = '0;
			dot_cnt = '0;
			cur_mode = MODE_HBLANK;
		end else if (tick) begin
			dot_cnt = dot_cnt + 1'b1;
			if (line_cnt >= FIRST_VBLANK)
				m = MODE_VBLANK;
			else if (dot_cnt <= SEARCH_END)
				m = MODE_SEARCH;
			else if (dot_cnt <= TRANSFER_END)
				m = MODE_TRANSFER;
			else
				m = MODE_HBLANK;
			if (m != cur_mode) begin
				cur_mode = m;
				r.hblank_start = (m == MODE_HBLANK);
				r.vblank_irq = (m == MODE_VBLANK);
				r.stat_irq = stat_rise();
			end
			// end of line
			if (dot_cnt >= DOTS_PER_LINE) begin
				dot_cnt = '0;
				line_cnt = (line_cnt >= LAST_LINE) ? '0 : line_cnt + 1'b1;
				match_q = (line_cnt == lyc);
				r.stat_irq = stat_rise() | r.stat_irq;
			end
		end
		r.line_number = line_cnt;
		r.lcd_mode = cur_mode;
		r.line_match = match_q;
		return r;
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fails++;
		end
	endfunction

	// Cycle limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Result side: check each status transaction, then decide ready for the next edge
	always @(posedge clk) begin
		result_t want;
		if (arst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
			if (status_due.size() == 0) begin
				$error("status transaction with no expectation waiting");
				fails++;
			end else begin
				want = status_due.pop_front();
				check_field("line_number", want.line_number, rsp_if.line_number);
				check_field("lcd_mode", want.lcd_mode, rsp_if.lcd_mode);
				check_field("line_match", want.line_match, rsp_if.line_match);
				check_field("stat_irq", want.stat_irq, rsp_if.stat_irq);
				check_field("vblank_irq", want.vblank_irq, rsp_if.vblank_irq);
				check_field("hblank_start", want.hblank_start, rsp_if.hblank_start);
			end
		end
		if (stall_hold > 0) begin
			stall_hold--;
			rsp_if.ready <= 1'b0;
		end else begin
			rsp_if.ready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	// Offer one dot; returns at the edge where it is accepted
	task automatic send_dot(input logic tick);
		while ($urandom_range(99) < src_idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.dot_tick <= tick;
		@(posedge clk);
		while (req_if.ready !== 1'b1)
			@(posedge clk);
		status_due.push_back(advance_dot(tick));
	endtask

	// Stop offering and wait until every status has come back
	task automatic settle();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (status_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write all three registers back to back; block must be idle
	task automatic cfg_apply(input logic lcd, input logic [3:0] en, input logic [7:0] cmp);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_LCD_ENABLE;
		cfg_wdata <= CFG_DATA_W'(lcd);
		@(posedge clk);
		cfg_index <= CFG_STAT_IRQ_ENABLE;
		cfg_wdata <= CFG_DATA_W'(en);
		@(posedge clk);
		cfg_index <= CFG_LINE_COMPARE;
		cfg_wdata <= cmp;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		lcd_on = lcd;
		irq_en = en;
		lyc = cmp;
	endtask

	task automatic set_idling(input int unsigned src, input int unsigned snk);
		src_idle_pct = src;
		snk_stall_pct = snk;
	endtask

	// Reset state, no-tick reports, LCD off and the STAT sources alone and combined
	task automatic test_directed_cases();
		set_idling(0, 0);
		send_dot(1'b0);
		send_dot(1'b1);
		send_dot(1'b0);
		settle();
		cfg_apply(1'b1, 4'hF, 8'h00);
		send_dot(1'b0);
		send_dot(1'b1);
		settle();
		// LCD off forces line 0, dot 0, hblank mode and no pulses whatever the tick
		cfg_apply(1'b0, 4'hF, 8'hFF);
		send_dot(1'b1);
		send_dot(1'b0);
		send_dot(1'b1);
		settle();
		// restart from hblank into search with only the mode 2 source
		cfg_apply(1'b1, EN_MODE2, 8'h00);
		send_dot(1'b1);
		send_dot(1'b1);
		settle();
		// line match source compares the live line
		cfg_apply(1'b1, EN_MATCH, 8'h00);
		send_dot(1'b1);
		send_dot(1'b0);
		settle();
		cfg_apply(1'b1, EN_MODE0 | EN_MODE1, 8'hFF);
		send_dot(1'b1);
		settle();
	endtask

	// Long receiver hold-off while the sender keeps offering
	task automatic test_output_backpressure();
		set_idling(0, 0);
		cfg_apply(1'b1, 4'($urandom_range(15)), 8'($urandom_range(3)));
		stall_hold = HOLD_CYCLES;
		repeat (60) send_dot($urandom_range(7) != 0);
		settle();
	endtask

	// Random ticks in chunks, registers changed between chunks, over four idling phases
	task automatic test_random_phases();
		int unsigned phase;
		int unsigned chunk;
		logic [7:0] cmp;
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					set_idling(0, 0);
				end
				1: begin
					set_idling(68, 0);
				end
				2: begin
					set_idling(0, 68);
				end
				default: begin
					set_idling(37, 37);
				end
			endcase
			for (chunk = 0; chunk < 4; chunk++) begin
				cmp = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(4));
				cfg_apply($urandom_range(5) != 0, 4'($urandom_range(15)), cmp);
				repeat (75) send_dot($urandom_range(7) != 0);
				settle();
			end
		end
	endtask

	// A whole line with every dot ticked: line end, coincidence flag and match source
	task automatic test_line_end();
		set_idling(0, 0);
		// one transaction with the LCD off restarts the line from dot 0
		cfg_apply(1'b0, 4'h0, 8'h00);
		send_dot(1'b1);
		settle();
		set_idling(37, 37);
		cfg_apply(1'b1, EN_MATCH, 8'd1);
		repeat (460) send_dot(1'b1);
		settle();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		req_if.valid = 1'b0;
		req_if.dot_tick = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_output_backpressure();
		test_random_phases();
		test_line_end();

		settle();
		if (fails == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
